// ----- src/touch_slider_jog_velocity_assert.svh -----
// Assertion macros used by the jog velocity top module.
`ifndef TOUCH_SLIDER_JOG_VELOCITY_ASSERT_SVH
`define TOUCH_SLIDER_JOG_VELOCITY_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define TSJV_CHECK(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("tsjv check failed");

// Same-cycle implication out of reset.
`define TSJV_CHECK_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsjv implication failed");

`endif

// ----- src/tsjv_pkg.sv -----
// Package: constants, types and register map of the jog velocity block.
`timescale 1ns / 1ps
package tsjv_pkg;

  localparam int MAX_PADS     = 8;
  localparam int NUM_PADS     = 8;
  localparam int READING_BITS = 16;
  localparam int FIELD_W      = 16;
  localparam int PCT_W        = 7;
  localparam int STEP_W       = 8;
  localparam int THR_W        = 15;
  // base * percent and 100 * (reading + 1) both stay below 2^(READING_BITS+7)
  localparam int PROD_W       = READING_BITS + PCT_W;
  localparam int PCT_DIV      = 100;
  localparam int POS_W        = 4;
  localparam logic [POS_W-1:0] POS_LOW  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_HIGH = POS_W'(9);
  localparam int VEL_W        = 16;
  localparam int VEL_MAX      = 32767;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;

  localparam logic [PCT_W-1:0]  PCT_RESET  = PCT_W'(80);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1);
  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(10);

  typedef enum logic [1:0] {
    REG_PERCENT = 2'd0,
    REG_STEP    = 2'd1,
    REG_THRESH  = 2'd2
  } reg_idx_t;

  localparam logic CMD_CAPTURE = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  typedef struct packed {
    logic [PCT_W-1:0]  touch_percent;
    logic [STEP_W-1:0] velocity_step;
    logic [THR_W-1:0]  jog_threshold;
  } cfg_t;

endpackage

// ----- src/tsjv_cfg.sv -----
// APB register file: touch percent, velocity step, jog threshold.
`timescale 1ns / 1ps
module tsjv_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tsjv_pkg::ADDR_W-1:0] paddr,
  input  logic [tsjv_pkg::DATA_W-1:0] pwdata,
  output logic [tsjv_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output tsjv_pkg::cfg_t             cfg
);

  tsjv_pkg::cfg_t    cfg_r;
  tsjv_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = tsjv_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // register writes on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.touch_percent <= tsjv_pkg::PCT_RESET;
      cfg_r.velocity_step <= tsjv_pkg::STEP_RESET;
      cfg_r.jog_threshold <= tsjv_pkg::THR_RESET;
    end else if (wr_en) begin
      unique case (idx)
        tsjv_pkg::REG_PERCENT: cfg_r.touch_percent <= pwdata[tsjv_pkg::PCT_W-1:0];
        tsjv_pkg::REG_STEP:    cfg_r.velocity_step <= pwdata[tsjv_pkg::STEP_W-1:0];
        tsjv_pkg::REG_THRESH:  cfg_r.jog_threshold <= pwdata[tsjv_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      tsjv_pkg::REG_PERCENT: prdata = tsjv_pkg::DATA_W'(cfg_r.touch_percent);
      tsjv_pkg::REG_STEP:    prdata = tsjv_pkg::DATA_W'(cfg_r.velocity_step);
      tsjv_pkg::REG_THRESH:  prdata = tsjv_pkg::DATA_W'(cfg_r.jog_threshold);
      default:               prdata = '0;
    endcase
  end

endmodule

// ----- src/tsjv_lane.sv -----
// One pad lane: baseline store, scaled products, touch compare.
`timescale 1ns / 1ps
module tsjv_lane (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             capture_en,
  input  logic                             load_en,
  input  logic [tsjv_pkg::FIELD_W-1:0]     reading,
  input  logic [tsjv_pkg::PCT_W-1:0]       percent,
  output logic                             touched
);

  localparam int RW = tsjv_pkg::READING_BITS;
  localparam int PW = tsjv_pkg::PROD_W;

  logic [RW-1:0] base_r;
  logic [RW-1:0] rd;
  logic [PW-1:0] prod_r, scaled_r;

  assign rd = reading[RW-1:0];

  // baseline capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (capture_en) begin
      base_r <= rd;
    end
  end

  // rd < floor(base*pct/100)  <=>  100*(rd+1) <= base*pct
  always_ff @(posedge clk) begin
    if (load_en) begin
      prod_r   <= PW'(base_r) * PW'(percent);
      scaled_r <= (PW'(rd) + PW'(1)) * PW'(tsjv_pkg::PCT_DIV);
    end
  end

  assign touched = (scaled_r <= prod_r);

endmodule

// ----- src/tsjv_merge.sv -----
// Merge stage: position pick, touch flag, velocity update, result register.
`timescale 1ns / 1ps
module tsjv_merge (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv_en,
  input  logic                               cmd,
  input  logic [tsjv_pkg::MAX_PADS-1:0]      mask,
  input  tsjv_pkg::cfg_t                     cfg,
  output logic signed [tsjv_pkg::VEL_W-1:0]  jog_velocity,
  output logic [tsjv_pkg::POS_W-1:0]         slider_position,
  output logic [tsjv_pkg::MAX_PADS-1:0]      pad_touched_mask,
  output logic                               touch_active,
  output logic                               jog_request
);

  localparam int VW = tsjv_pkg::VEL_W + 2;
  localparam int PS = tsjv_pkg::POS_W;
  localparam logic signed [VW-1:0] VMAX = VW'(tsjv_pkg::VEL_MAX);

  // held_r doubles as the previous position: they agree after every tick
  logic [PS-1:0]                    held_r, held_nxt, pos;
  logic                             flag_r, flag_nxt;
  logic signed [tsjv_pkg::VEL_W-1:0] vel_r, vel_nxt;
  logic signed [VW-1:0]             v, st;
  logic [tsjv_pkg::MAX_PADS-1:0]    mask_eff;

  logic signed [tsjv_pkg::VEL_W-1:0] out_vel_r;
  logic [PS-1:0]                    out_pos_r;
  logic [tsjv_pkg::MAX_PADS-1:0]    out_mask_r;
  logic                             out_flag_r;
  logic [tsjv_pkg::VEL_W-1:0]       mag;

  assign mask_eff = (cmd == tsjv_pkg::CMD_TICK) ? mask : '0;

  // lowest touched slider pad
  always_comb begin
    pos = '0;
    for (int k = tsjv_pkg::MAX_PADS - 1; k >= 1; k--) begin
      if (mask_eff[k]) pos = PS'(k + 2);
    end
  end

  // next state of a tick
  always_comb begin
    held_nxt = (pos != '0) ? pos : held_r;
    if (pos != '0)        flag_nxt = 1'b1;
    else if (!mask_eff[0]) flag_nxt = 1'b0;
    else                  flag_nxt = flag_r;

    st = VW'(cfg.velocity_step);
    v  = VW'(vel_r);

    // step on a position move
    if (held_nxt != held_r) begin
      if (held_nxt > tsjv_pkg::POS_LOW && held_nxt < tsjv_pkg::POS_HIGH) begin
        v = (held_nxt > held_r) ? v + st : v - st;
      end else if (held_nxt == tsjv_pkg::POS_LOW && held_r == tsjv_pkg::POS_HIGH) begin
        v = v + st;
      end else if (held_nxt == tsjv_pkg::POS_HIGH && held_r == tsjv_pkg::POS_LOW) begin
        v = v - st;
      end
      if (v > VMAX)       v = VMAX;
      else if (v < -VMAX) v = -VMAX;
    end

    // decay toward zero while untouched; sign bit picks the direction
    if (!flag_nxt && v != '0) begin
      if (!v[VW-1]) v = (v > st) ? v - st : '0;
      else          v = (-v > st) ? v + st : '0;
    end

    vel_nxt = v[tsjv_pkg::VEL_W-1:0];
  end

  // state update, ticks only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      flag_r <= 1'b0;
      vel_r  <= '0;
    end else if (adv_en && cmd == tsjv_pkg::CMD_TICK) begin
      held_r <= held_nxt;
      flag_r <= flag_nxt;
      vel_r  <= vel_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (adv_en) begin
      out_mask_r <= mask_eff;
      if (cmd == tsjv_pkg::CMD_TICK) begin
        out_vel_r  <= vel_nxt;
        out_pos_r  <= held_nxt;
        out_flag_r <= flag_nxt;
      end else begin
        out_vel_r  <= vel_r;
        out_pos_r  <= held_r;
        out_flag_r <= flag_r;
      end
    end
  end

  assign mag = (out_vel_r < 0) ? -out_vel_r : out_vel_r;

  assign jog_velocity     = out_vel_r;
  assign slider_position  = out_pos_r;
  assign pad_touched_mask = out_mask_r;
  assign touch_active     = out_flag_r;
  assign jog_request      = (mag > tsjv_pkg::VEL_W'(cfg.jog_threshold));

endmodule

// ----- src/touch_slider_jog_velocity.sv -----
// A request accepted into the lane product register reaches out_valid when the merge
// result register takes it. Throughput: one request per cycle; these two registers
// form a two-stage pipe that advances whenever out_stall is low or out_valid is low.
// Reset (rst_n, synchronous, active low): baselines, position, touch flag and
// velocity clear to zero; registers return to percent 80, step 1, threshold 10.
`timescale 1ns / 1ps
module touch_slider_jog_velocity (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cmd,
  input  logic [15:0]                       in_home_reading,
  input  logic [15:0]                       in_pad3_reading,
  input  logic [15:0]                       in_pad4_reading,
  input  logic [15:0]                       in_pad5_reading,
  input  logic [15:0]                       in_pad6_reading,
  input  logic [15:0]                       in_pad7_reading,
  input  logic [15:0]                       in_pad8_reading,
  input  logic [15:0]                       in_pad9_reading,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [15:0]                out_jog_velocity,
  output logic [3:0]                        out_slider_position,
  output logic [7:0]                        out_pad_touched_mask,
  output logic                              out_touch_active,
  output logic                              out_jog_request,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tsjv_pkg::ADDR_W-1:0]       paddr,
  input  logic [tsjv_pkg::DATA_W-1:0]       pwdata,
  output logic [tsjv_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  `include "touch_slider_jog_velocity_assert.svh"

  tsjv_pkg::cfg_t cfg;
  logic [tsjv_pkg::FIELD_W-1:0] rd [tsjv_pkg::MAX_PADS];
  logic [tsjv_pkg::MAX_PADS-1:0] mask;
  logic s1_valid_r, out_valid_r;
  logic s1_cmd_r;
  logic out_free, adv_en, in_acc, capture_en;

  tsjv_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign rd[0] = in_home_reading;
  assign rd[1] = in_pad3_reading;
  assign rd[2] = in_pad4_reading;
  assign rd[3] = in_pad5_reading;
  assign rd[4] = in_pad6_reading;
  assign rd[5] = in_pad7_reading;
  assign rd[6] = in_pad8_reading;
  assign rd[7] = in_pad9_reading;

  // pipe control: result register frees when empty or taken
  assign out_free   = !out_valid_r || !out_stall;
  assign adv_en     = s1_valid_r && out_free;
  assign in_stall   = s1_valid_r && !out_free;
  assign in_acc     = in_valid && !in_stall;
  assign capture_en = in_acc && (in_cmd == tsjv_pkg::CMD_CAPTURE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc)        s1_valid_r <= 1'b1;
      else if (adv_en)   s1_valid_r <= 1'b0;
      if (adv_en)        out_valid_r <= 1'b1;
      else if (out_free) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_cmd_r <= in_cmd;
  end

  // one lane per pad
  for (genvar k = 0; k < tsjv_pkg::MAX_PADS; k++) begin : g_lane
    if (k < tsjv_pkg::NUM_PADS) begin : g_on
      tsjv_lane u_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .capture_en (capture_en),
        .load_en    (in_acc),
        .reading    (rd[k]),
        .percent    (cfg.touch_percent),
        .touched    (mask[k])
      );
    end else begin : g_off
      assign mask[k] = 1'b0;
    end
  end

  tsjv_merge u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv_en           (adv_en),
    .cmd              (s1_cmd_r),
    .mask             (mask),
    .cfg              (cfg),
    .jog_velocity     (out_jog_velocity),
    .slider_position  (out_slider_position),
    .pad_touched_mask (out_pad_touched_mask),
    .touch_active     (out_touch_active),
    .jog_request      (out_jog_request)
  );

  assign out_valid = out_valid_r;

  // stall only while the lane stage holds a request
  `TSJV_CHECK_IMP(a_stall_full, in_stall, s1_valid_r)
  // velocity stays inside the saturation range
  `TSJV_CHECK_IMP(a_vel_sat, out_valid, out_jog_velocity != 16'sh8000)
  // held position is zero or a slider pad
  `TSJV_CHECK_IMP(a_pos_range, out_valid,
    out_slider_position == 4'd0 ||
    (out_slider_position >= 4'd3 && out_slider_position <= 4'd9))
  // a touched slider pad always sets the touch flag
  `TSJV_CHECK_IMP(a_touch_flag, out_valid && out_pad_touched_mask[7:1] != 7'd0,
    out_touch_active)

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the touch slider jog velocity block.
`timescale 1ns / 1ps
module tb;

  // One request: command plus readings, rd[0] is the home pad, rd[k] is pad k+2
  typedef struct packed {
    logic             cmd;
    logic [7:0][15:0] rd;
  } pad_req_t;

  typedef struct packed {
    logic signed [15:0] vel;
    logic [3:0]         pos;
    logic [7:0]         mask;
    logic               active;
    logic               jreq;
  } slider_rpt_t;

  localparam logic [15:0] RD_MASK = 16'((32'd1 << tsjv_pkg::READING_BITS) - 1);

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_cmd = tsjv_pkg::CMD_CAPTURE;
  logic [15:0] in_home_reading = '0;
  logic [15:0] in_pad3_reading = '0;
  logic [15:0] in_pad4_reading = '0;
  logic [15:0] in_pad5_reading = '0;
  logic [15:0] in_pad6_reading = '0;
  logic [15:0] in_pad7_reading = '0;
  logic [15:0] in_pad8_reading = '0;
  logic [15:0] in_pad9_reading = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_jog_velocity;
  logic [3:0]         out_slider_position;
  logic [7:0]         out_pad_touched_mask;
  logic               out_touch_active;
  logic               out_jog_request;

  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [tsjv_pkg::ADDR_W-1:0] paddr = '0;
  logic [tsjv_pkg::DATA_W-1:0] pwdata = '0;
  logic [tsjv_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  touch_slider_jog_velocity uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_cmd               (in_cmd),
    .in_home_reading      (in_home_reading),
    .in_pad3_reading      (in_pad3_reading),
    .in_pad4_reading      (in_pad4_reading),
    .in_pad5_reading      (in_pad5_reading),
    .in_pad6_reading      (in_pad6_reading),
    .in_pad7_reading      (in_pad7_reading),
    .in_pad8_reading      (in_pad8_reading),
    .in_pad9_reading      (in_pad9_reading),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_jog_velocity     (out_jog_velocity),
    .out_slider_position  (out_slider_position),
    .out_pad_touched_mask (out_pad_touched_mask),
    .out_touch_active     (out_touch_active),
    .out_jog_request      (out_jog_request),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  // Stimulus and scoreboard state
  pad_req_t    pad_request_q[$];
  slider_rpt_t predicted_reports[$];
  int sent_cnt = 0;
  int req_cnt = 0;
  int rpt_cnt = 0;
  int capture_cnt = 0;
  int setting_cnt = 0;
  int err_cnt = 0;
  int peak_mag = 0;
  int gap_odds = 6;
  int stall_odds = 6;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit req_taken = 1'b0;

  // Predictor copy of the block state and its registers
  logic [15:0]                 pad_base [8];
  logic [3:0]                  held_pos;
  logic [3:0]                  prev_pos;
  int                          jog_vel;
  bit                          touch_flag;
  logic [tsjv_pkg::PCT_W-1:0]  pct_cfg;
  logic [tsjv_pkg::STEP_W-1:0] step_cfg;
  logic [tsjv_pkg::THR_W-1:0]  thr_cfg;

  // Baselines as the stimulus side last sent them
  logic [15:0] gen_base [8];
  int gen_pos = 0;
  int gen_dir = 1;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("timeout: %0d of %0d requests reported", rpt_cnt, sent_cnt);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  function automatic slider_rpt_t predict_slider_report(pad_req_t r);
    slider_rpt_t o;
    logic [7:0] hit;
    logic [3:0] pos;
    int k;
    int thr;
    int vstep;
    int mag;
    hit = '0;
    pos = '0;
    vstep = int'(step_cfg);
    if (r.cmd == tsjv_pkg::CMD_CAPTURE) begin
      for (k = 0; k < 8; k++)
        if (k < tsjv_pkg::NUM_PADS) pad_base[k] = r.rd[k] & RD_MASK;
    end else begin
      // per-pad touch compare against the scaled baseline
      for (k = 0; k < 8; k++) begin
        thr = int'(pad_base[k]) * int'(pct_cfg) / tsjv_pkg::PCT_DIV;
        if (k < tsjv_pkg::NUM_PADS && int'(r.rd[k] & RD_MASK) < thr) hit[k] = 1'b1;
      end
      // lowest touched slider pad wins
      for (k = 7; k >= 1; k--)
        if (hit[k]) pos = 4'(k + 2);
      if (pos != 0) begin
        held_pos = pos;
        touch_flag = 1'b1;
      end else if (!hit[0]) begin
        touch_flag = 1'b0;
      end
      // step on a position change; wrap between the ends counts as a move
      if (held_pos != prev_pos) begin
        if (held_pos > tsjv_pkg::POS_LOW && held_pos < tsjv_pkg::POS_HIGH)
          jog_vel = (held_pos > prev_pos) ? jog_vel + vstep : jog_vel - vstep;
        else if (held_pos == tsjv_pkg::POS_LOW && prev_pos == tsjv_pkg::POS_HIGH)
          jog_vel = jog_vel + vstep;
        else if (held_pos == tsjv_pkg::POS_HIGH && prev_pos == tsjv_pkg::POS_LOW)
          jog_vel = jog_vel - vstep;
        if (jog_vel > tsjv_pkg::VEL_MAX) jog_vel = tsjv_pkg::VEL_MAX;
        if (jog_vel < -tsjv_pkg::VEL_MAX) jog_vel = -tsjv_pkg::VEL_MAX;
        prev_pos = held_pos;
      end
      // decay toward zero while released
      if (!touch_flag && jog_vel != 0) begin
        if (jog_vel > 0) jog_vel = (jog_vel > vstep) ? jog_vel - vstep : 0;
        else jog_vel = (-jog_vel > vstep) ? jog_vel + vstep : 0;
      end
    end
    mag = (jog_vel < 0) ? -jog_vel : jog_vel;
    if (mag > peak_mag) peak_mag = mag;
    o.vel = 16'(jog_vel);
    o.pos = held_pos;
    o.mask = hit;
    o.active = touch_flag;
    o.jreq = (mag > int'(thr_cfg));
    return o;
  endfunction

  task automatic check_report(slider_rpt_t got, slider_rpt_t want);
    if (got.vel !== want.vel) report_mismatch("jog_velocity", int'(got.vel), int'(want.vel));
    if (got.pos !== want.pos) report_mismatch("slider_position", got.pos, want.pos);
    if (got.mask !== want.mask) report_mismatch("pad_touched_mask", got.mask, want.mask);
    if (got.active !== want.active)
      report_mismatch("touch_active", got.active, want.active);
    if (got.jreq !== want.jreq) report_mismatch("jog_request", got.jreq, want.jreq);
  endtask

  // Request driver: a new request goes out only once the current one is taken
  always @(negedge clk) begin
    pad_req_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0) begin
        gap_left <= $urandom_range(10, 0);
        in_valid <= 1'b0;
      end else if (pad_request_q.size() != 0) begin
        r = pad_request_q.pop_front();
        in_valid <= 1'b1;
        in_cmd <= r.cmd;
        in_home_reading <= r.rd[0];
        in_pad3_reading <= r.rd[1];
        in_pad4_reading <= r.rd[2];
        in_pad5_reading <= r.rd[3];
        in_pad6_reading <= r.rd[4];
        in_pad7_reading <= r.rd[5];
        in_pad8_reading <= r.rd[6];
        in_pad9_reading <= r.rd[7];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random bursts, plus one long hold-off to back up the pipe
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && req_cnt >= 600) begin
      hold_left <= 79;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (stall_odds != 0 && $urandom_range(stall_odds - 1, 0) == 0) begin
      stall_left <= $urandom_range(10, 0);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predict on each accepted request, check each accepted report
  always @(posedge clk) begin
    pad_req_t    seen;
    slider_rpt_t got;
    if (!rst_n) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        seen.cmd = in_cmd;
        seen.rd = {in_pad9_reading, in_pad8_reading, in_pad7_reading, in_pad6_reading,
                   in_pad5_reading, in_pad4_reading, in_pad3_reading, in_home_reading};
        predicted_reports.push_back(predict_slider_report(seen));
        req_cnt++;
      end
      if (out_valid && !out_stall) begin
        got.vel = out_jog_velocity;
        got.pos = out_slider_position;
        got.mask = out_pad_touched_mask;
        got.active = out_touch_active;
        got.jreq = out_jog_request;
        rpt_cnt++;
        if (predicted_reports.size() == 0) report_mismatch("unexpected report", rpt_cnt, 0);
        else check_report(got, predicted_reports.pop_front());
      end
    end
  end

  function automatic logic [7:0] pad_bit(int p);
    return 8'(1 << (p - 2));
  endfunction

  // Reading that lands on the wanted side of the pad's touch threshold
  function automatic logic [15:0] pick_reading(int k, bit hit);
    int th;
    int hi;
    th = int'(gen_base[k]) * int'(pct_cfg) / tsjv_pkg::PCT_DIV;
    hi = (th - 1 > 65535) ? 65535 : th - 1;
    if (hit && th > 0)
      return ($urandom_range(3, 0) == 0) ? 16'(hi) : 16'($urandom_range(hi, 0));
    if (!hit && th <= 65535)
      return ($urandom_range(3, 0) == 0) ? 16'(th) : 16'($urandom_range(65535, th));
    return 16'($urandom);
  endfunction

  task automatic push_req(pad_req_t r);
    int k;
    if (r.cmd == tsjv_pkg::CMD_CAPTURE) begin
      for (k = 0; k < 8; k++) gen_base[k] = r.rd[k];
      capture_cnt++;
    end
    pad_request_q.push_back(r);
    sent_cnt++;
  endtask

  task automatic push_touch(logic [7:0] hits);
    pad_req_t r;
    int k;
    r.cmd = tsjv_pkg::CMD_TICK;
    for (k = 0; k < 8; k++) r.rd[k] = pick_reading(k, hits[k]);
    push_req(r);
  endtask

  task automatic push_capture_rand();
    pad_req_t r;
    int k;
    int pick;
    r.cmd = tsjv_pkg::CMD_CAPTURE;
    for (k = 0; k < 8; k++) begin
      pick = $urandom_range(7, 0);
      if (pick == 0) r.rd[k] = '0;
      else if (pick == 1) r.rd[k] = 16'($urandom);
      else r.rd[k] = 16'($urandom_range(65535, 8000));
    end
    push_req(r);
  endtask

  // Slider walk with a drifting direction so velocity builds up
  task automatic push_walk();
    logic [7:0] hits;
    int p;
    int k;
    if (gen_pos == 0 || $urandom_range(7, 0) == 0) p = $urandom_range(9, 3);
    else if ($urandom_range(3, 0) != 0) p = gen_pos + gen_dir;
    else p = gen_pos - gen_dir;
    if (p > 9) p = 3;
    if (p < 3) p = 9;
    if ($urandom_range(39, 0) == 0) gen_dir = -gen_dir;
    hits = pad_bit(p);
    for (k = p + 1; k <= 9; k++)
      if ($urandom_range(3, 0) == 0) hits = hits | pad_bit(k);
    if ($urandom_range(3, 0) == 0) hits[0] = 1'b1;
    gen_pos = p;
    push_touch(hits);
  endtask

  task automatic wait_drained();
    while (rpt_cnt != sent_cnt) @(negedge clk);
  endtask

  task automatic cfg_write(tsjv_pkg::reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= tsjv_pkg::ADDR_W'(int'(idx) * 4);
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      tsjv_pkg::REG_PERCENT: pct_cfg = val[tsjv_pkg::PCT_W-1:0];
      tsjv_pkg::REG_STEP:    step_cfg = val[tsjv_pkg::STEP_W-1:0];
      tsjv_pkg::REG_THRESH:  thr_cfg = val[tsjv_pkg::THR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic cfg_read(tsjv_pkg::reg_idx_t idx);
    logic [31:0] want;
    case (idx)
      tsjv_pkg::REG_PERCENT: want = 32'(pct_cfg);
      tsjv_pkg::REG_STEP:    want = 32'(step_cfg);
      tsjv_pkg::REG_THRESH:  want = 32'(thr_cfg);
      default:               want = '0;
    endcase
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= tsjv_pkg::ADDR_W'(int'(idx) * 4);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) report_mismatch("register readback", int'(prdata), int'(want));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_registers(int pct, int vstep, int thr);
    wait_drained();
    cfg_write(tsjv_pkg::REG_PERCENT, pct);
    cfg_write(tsjv_pkg::REG_STEP, vstep);
    cfg_write(tsjv_pkg::REG_THRESH, thr);
    cfg_read(tsjv_pkg::REG_PERCENT);
    cfg_read(tsjv_pkg::REG_STEP);
    cfg_read(tsjv_pkg::REG_THRESH);
    setting_cnt++;
  endtask

  task automatic run_random(int pct, int vstep, int thr, int n, int odds);
    pad_req_t r;
    int i;
    int k;
    int pick;
    set_registers(pct, vstep, thr);
    gap_odds = odds;
    stall_odds = odds;
    push_capture_rand();
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(99, 0);
      if (pick < 4) begin
        push_capture_rand();
      end else if (pick < 10) begin
        // raw noise, either command
        r.cmd = 1'($urandom);
        for (k = 0; k < 8; k++) r.rd[k] = 16'($urandom);
        push_req(r);
      end else if (pick < 22) begin
        push_touch({7'd0, 1'($urandom)});
      end else begin
        push_walk();
      end
    end
  endtask

  initial begin
    pad_req_t r;
    int i;
    int p;
    // model reset state
    for (i = 0; i < 8; i++) begin
      pad_base[i] = '0;
      gen_base[i] = '0;
    end
    held_pos = '0;
    prev_pos = '0;
    jog_vel = 0;
    touch_flag = 1'b0;
    pct_cfg = tsjv_pkg::PCT_RESET;
    step_cfg = tsjv_pkg::STEP_RESET;
    thr_cfg = tsjv_pkg::THR_RESET;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values of the registers
    cfg_read(tsjv_pkg::REG_PERCENT);
    cfg_read(tsjv_pkg::REG_STEP);
    cfg_read(tsjv_pkg::REG_THRESH);
    setting_cnt++;

    // directed: zero baselines never touch
    r.cmd = tsjv_pkg::CMD_TICK;
    r.rd = '0;
    push_req(r);
    r.rd = '1;
    push_req(r);
    r.cmd = tsjv_pkg::CMD_CAPTURE;
    push_req(r);
    push_touch(pad_bit(5));                  // first touch into the middle
    push_touch(pad_bit(9));                  // jump into the far end: no step
    push_touch(pad_bit(3));                  // wrap 9 to 3 counts up
    push_touch(pad_bit(9));                  // wrap 3 to 9 counts down
    push_touch(pad_bit(3));
    push_touch(pad_bit(4));
    push_touch(pad_bit(6) | pad_bit(8));     // lowest pad wins
    push_touch(pad_bit(5));
    push_touch(8'h01);                       // home pad alone keeps the flag
    push_touch(8'h00);                       // release, decay
    push_touch(8'h00);
    push_touch(8'hFF);
    r.cmd = tsjv_pkg::CMD_TICK;
    r.rd = '0;
    push_req(r);
    // just at and just under the threshold
    r.rd = {8{16'd52428}};
    r.rd[5] = 16'd52427;
    push_req(r);
    r.rd = '1;
    push_req(r);
    r.cmd = tsjv_pkg::CMD_CAPTURE;
    r.rd = {16'hFFFF, 16'd2, 16'd1, 16'd100, 16'd200, 16'h8000, 16'h7FFF, 16'd0};
    push_req(r);
    r.cmd = tsjv_pkg::CMD_TICK;
    r.rd = '0;
    push_req(r);
    r.rd = {16'h0000, 16'd1, 16'd0, 16'd79, 16'd160, 16'h6666, 16'h6665, 16'hFFFF};
    push_req(r);
    r.cmd = tsjv_pkg::CMD_CAPTURE;
    r.rd = '0;
    push_req(r);
    r.cmd = tsjv_pkg::CMD_TICK;
    push_req(r);

    // drive velocity into both rails with the largest step
    set_registers(100, 255, 32767);
    r.cmd = tsjv_pkg::CMD_CAPTURE;
    r.rd = '1;
    push_req(r);
    for (i = 0; i < 25; i++)
      for (p = 3; p <= 9; p++) push_touch(pad_bit(p));
    for (i = 0; i < 50; i++)
      for (p = 9; p >= 3; p--) push_touch(pad_bit(p));
    set_registers(100, 255, 0);
    for (i = 0; i < 12; i++) push_touch(8'h00);

    // random phases across register settings, quiet at the end
    run_random(80, 1, 10, 180, 5);
    run_random(1, 3, 0, 180, 0);
    run_random(127, 255, 32767, 180, 4);
    run_random(0, 5, 2, 180, 8);
    run_random(50, 0, 0, 180, 3);
    run_random(95, 128, 1000, 180, 6);
    run_random(70, 2, 20, 180, 5);
    run_random(100, 200, 300, 180, 0);

    wait_drained();
    repeat (8) @(posedge clk);
    if (predicted_reports.size() != 0)
      report_mismatch("reports never seen", predicted_reports.size(), 0);
    $display("Covered %0d requests (%0d baseline captures) over %0d register settings,",
             req_cnt, capture_cnt, setting_cnt);
    $display("peak |velocity| %0d, %0d reports checked, %0d mismatches.",
             peak_mag, rpt_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
